// File: rtl/ipv4fd_pkg.sv
// Package for the IPv4 forwarding decision core.
// Holds input and result beat types, action and kind codes, and checksum helpers.
// Depends on nothing.
package ipv4fd_pkg;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [2:0] ACT_UPDATED   = 3'd0;
  localparam logic [2:0] ACT_SHORT     = 3'd1;
  localparam logic [2:0] ACT_BAD_CKSUM = 3'd2;
  localparam logic [2:0] ACT_ECHO      = 3'd3;
  localparam logic [2:0] ACT_PORT_UNR  = 3'd4;
  localparam logic [2:0] ACT_TTL_EXC   = 3'd5;
  localparam logic [2:0] ACT_NET_UNR   = 3'd6;
  localparam logic [2:0] ACT_FORWARD   = 3'd7;

  localparam logic [3:0] ICMP_ECHO_REPLY = 4'd0;
  localparam logic [3:0] ICMP_DEST_UNR   = 4'd3;
  localparam logic [3:0] ICMP_TIME_EXC   = 4'd11;
  localparam logic [1:0] CODE_NET        = 2'd0;
  localparam logic [1:0] CODE_PORT       = 2'd3;

  localparam logic [15:0] MIN_FRAME  = 16'd34;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] frame_len;
    logic [31:0] hdr_word0;
    logic [31:0] hdr_word1;
    logic [31:0] hdr_word2;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [3:0]  route_index;
    logic [31:0] route_dest;
    logic [31:0] route_mask;
    logic [31:0] route_gateway;
    logic [1:0]  route_port;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  out_port;
    logic [31:0] next_hop;
    logic [7:0]  new_ttl;
    logic [15:0] new_checksum;
    logic [3:0]  reply_type;
    logic [1:0]  reply_code;
  } out_beat_t;

  // Best-match candidate handed from cell to cell.
  typedef struct packed {
    logic        found;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [1:0]  port;
  } cand_t;

  // Unfolded sum of the ten halfwords of five words, 20 bits wide.
  function automatic logic [19:0] sum_words(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d,
                                            input logic [31:0] e);
    sum_words = 20'(a[31:16]) + 20'(a[15:0]) + 20'(b[31:16]) + 20'(b[15:0])
              + 20'(c[31:16]) + 20'(c[15:0]) + 20'(d[31:16]) + 20'(d[15:0])
              + 20'(e[31:16]) + 20'(e[15:0]);
  endfunction

  function automatic logic [15:0] fold_sum(input logic [19:0] s);
    logic [16:0] t;
    logic [16:0] u;
    t = 17'(s[19:16]) + 17'(s[15:0]);
    u = t + 17'(t[16]);
    fold_sum = ~u[15:0];
  endfunction

endpackage

// File: rtl/ipv4fd_cell.sv
// One route entry cell of the longest-prefix match chain.
// Depends on ipv4fd_pkg.
module ipv4fd_cell
  import ipv4fd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        clr_en,
  input  logic [31:0] wr_dest,
  input  logic [31:0] wr_mask,
  input  logic [31:0] wr_gateway,
  input  logic [1:0]  wr_port,
  input  logic [31:0] dst,
  input  cand_t       cand_in,
  output cand_t       cand_out
);

  logic        valid;
  logic [31:0] prefix;
  logic [31:0] mask;
  logic [31:0] gateway;
  logic [1:0]  port;
  logic        hit;

  // Entry storage; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_en) begin
      valid <= 1'b1;
    end else if (clr_en) begin
      valid <= 1'b0;
    end
    if (wr_en) begin
      prefix  <= wr_dest;
      mask    <= wr_mask;
      gateway <= wr_gateway;
      port    <= wr_port;
    end
  end

  // Cells are visited from high index to low, so a tie lets the lower index win.
  assign hit = valid && ((mask & dst) == prefix) && (!cand_in.found || mask >= cand_in.mask);

  always_comb begin
    cand_out = cand_in;
    if (hit) begin
      cand_out = '{found: 1'b1, mask: mask, gateway: gateway, port: port};
    end
  end

endmodule

// File: rtl/ipv4fd_chain.sv
// Row of route cells with a registered candidate walking one cell per cycle.
// Depends on ipv4fd_pkg and ipv4fd_cell.
module ipv4fd_chain
  import ipv4fd_pkg::*;
#(
  parameter int ROUTE_ENTRIES = 16,
  parameter int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1
)(
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic          clr_en,
  input  logic [3:0]    wr_index,
  input  logic [31:0]   wr_dest,
  input  logic [31:0]   wr_mask,
  input  logic [31:0]   wr_gateway,
  input  logic [1:0]    wr_port,
  input  logic [31:0]   dst,
  input  logic          search_start,
  input  logic [IW-1:0] step,
  output cand_t         best
);

  cand_t cand_pipe;
  cand_t cand_next [ROUTE_ENTRIES];

  // Every cell sees the running candidate; only the cell picked by step is registered.
  for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_cell
    logic sel;
    assign sel = ({28'd0, wr_index} == 32'(g));
    ipv4fd_cell u_cell (
      .clk(clk), .rst(rst),
      .wr_en(wr_en && sel), .clr_en(clr_en && sel),
      .wr_dest(wr_dest), .wr_mask(wr_mask), .wr_gateway(wr_gateway), .wr_port(wr_port),
      .dst(dst), .cand_in(cand_pipe), .cand_out(cand_next[g])
    );
  end

  // Candidate register: cleared at search start, updated by the selected cell.
  always_ff @(posedge clk) begin
    if (rst || search_start) begin
      cand_pipe <= '0;
    end else begin
      cand_pipe <= cand_next[step];
    end
  end

  assign best = cand_pipe;

endmodule

// File: rtl/ipv4_forwarding_decision_core.sv
// Top level of the IPv4 forwarding decision core.
// Depends on ipv4fd_pkg and ipv4fd_chain.
//
// Use: drive an input beat with start high while busy is low. The block
// answers each item with one result beat on result, marked by done for a
// single cycle; the receiver cannot stall it.
// Route writes and clears, unknown kinds and too-short headers are answered
// from the check state. Headers dropped for a bad checksum, answered locally
// or expired are answered on the first search step, and all others from the
// report state: the match walks the row of route cells one cell per cycle,
// highest index first, and that walk sets the rate.
// busy is high from acceptance and drops in the cycle that shows the result
// beat, so the next item can be accepted at the edge that ends that cycle.
// Interface registers are written on the cfg channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high.
// Reset (rst, synchronous) clears the interface registers and all route valid bits, and
// returns the block to idle with no result pending.
module ipv4_forwarding_decision_core
  import ipv4fd_pkg::*;
#(
  parameter int ROUTE_ENTRIES = 16,
  parameter int NUM_PORTS     = 4
)(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  item,
  output logic      done,
  output out_beat_t result,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_STEP = IW'(ROUTE_ENTRIES - 1);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SEARCH, S_REPORT} state_t;

  state_t      state;
  in_beat_t    hold;
  logic [31:0] iface_ip [4];
  logic [3:0]  iface_enable;
  logic [IW-1:0] step;
  logic [15:0] cks_in;
  logic [15:0] cks_out;
  logic [15:0] cks_new;
  logic        is_local;
  logic        accept;
  cand_t       best;
  logic [7:0]  ttl;

  assign cfg_ready = 1'b1;
  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign ttl = hold.hdr_word2[31:24];

  // Interface address registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      iface_ip     <= '{default: '0};
      iface_enable <= '0;
    end else if (cfg_valid) begin
      if (cfg_index < 3'd4) begin
        iface_ip[cfg_index[1:0]] <= cfg_data;
      end else if (cfg_index == 3'd4) begin
        iface_enable <= cfg_data[3:0];
      end
    end
  end

  // Checksums are registered when the header lands, one fold each.
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      cks_in  <= fold_sum(sum_words(hold.hdr_word0, hold.hdr_word1,
                                    {hold.hdr_word2[31:16], 16'd0},
                                    hold.src_addr, hold.dst_addr));
      cks_new <= fold_sum(sum_words(hold.hdr_word0, hold.hdr_word1,
                                    {ttl - 8'd1, hold.hdr_word2[23:16], 16'd0},
                                    hold.src_addr, hold.dst_addr));
    end
  end
  assign cks_out = cks_in;

  // Local address compare.
  always_comb begin
    is_local = 1'b0;
    for (int j = 0; j < 4; j++) begin
      if (j < NUM_PORTS && iface_enable[j] && iface_ip[j] == hold.dst_addr) begin
        is_local = 1'b1;
      end
    end
  end

  ipv4fd_chain #(.ROUTE_ENTRIES(ROUTE_ENTRIES), .IW(IW)) u_chain (
    .clk(clk), .rst(rst),
    .wr_en(accept && item.kind == KIND_WRITE),
    .clr_en(accept && item.kind == KIND_CLEAR),
    .wr_index(item.route_index),
    .wr_dest(item.route_dest), .wr_mask(item.route_mask),
    .wr_gateway(item.route_gateway), .wr_port(item.route_port),
    .dst(hold.dst_addr),
    .search_start(state == S_CHECK),
    .step(step),
    .best(best)
  );

  // Control and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            hold  <= item;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          result <= '0;
          step   <= LAST_STEP;
          state  <= S_IDLE;
          done   <= 1'b1;
          if (hold.kind == KIND_HEADER) begin
            if (hold.frame_len < MIN_FRAME) begin
              result.action <= ACT_SHORT;
            end else begin
              state <= S_SEARCH;
              done  <= 1'b0;
            end
          end
        end
        S_SEARCH: begin
          if (step == LAST_STEP && cks_out != hold.hdr_word2[15:0]) begin
            result.action <= ACT_BAD_CKSUM;
            state <= S_IDLE;
            done  <= 1'b1;
          end else if (step == LAST_STEP && is_local) begin
            if (hold.hdr_word2[23:16] == PROTO_ICMP) begin
              result.action <= ACT_ECHO;
            end else begin
              result.action     <= ACT_PORT_UNR;
              result.reply_type <= ICMP_DEST_UNR;
              result.reply_code <= CODE_PORT;
            end
            state <= S_IDLE;
            done  <= 1'b1;
          end else if (step == LAST_STEP && ttl <= 8'd1) begin
            result.action     <= ACT_TTL_EXC;
            result.reply_type <= ICMP_TIME_EXC;
            state <= S_IDLE;
            done  <= 1'b1;
          end else if (step == '0) begin
            state <= S_REPORT;
          end else begin
            step <= step - IW'(1);
          end
        end
        S_REPORT: begin
          if (best.found) begin
            result.action       <= ACT_FORWARD;
            result.out_port     <= best.port;
            result.next_hop     <= best.gateway;
            result.new_ttl      <= ttl - 8'd1;
            result.new_checksum <= cks_new;
          end else begin
            result.action     <= ACT_NET_UNR;
            result.reply_type <= ICMP_DEST_UNR;
            result.reply_code <= CODE_NET;
          end
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result beat leaves the block idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("result shown while busy");
  // An accepted item always raises busy next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accept did not raise busy");
  // Forward results never report an ICMP type.
  a_fwd_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.action == ACT_FORWARD) |-> result.reply_type == ICMP_ECHO_REPLY)
    else $error("forward with ICMP type");

endmodule

// File: dv/tb_top.sv
// Testbench for the IPv4 forwarding decision core: route updates, header drops,
// local answers, TTL expiry and longest-prefix forwarding, checked against a predictor.
// Depends on ipv4fd_pkg and ipv4_forwarding_decision_core.
module tb_top
  import ipv4fd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ROUTES = 16;
  localparam int N_PORTS  = 4;

  localparam logic [2:0] REG_IFACE0 = 3'd0;
  localparam logic [2:0] REG_IFACE1 = 3'd1;
  localparam logic [2:0] REG_IFACE2 = 3'd2;
  localparam logic [2:0] REG_IFACE3 = 3'd3;
  localparam logic [2:0] REG_ENABLE = 3'd4;

  // Kind code that the block does not define.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Scoreboard: holds its own copy of the table and registers, and the queue
  // of forwarding decisions still owed by the block.
  class fwd_scoreboard;
    logic [31:0] iface_addr [4];
    logic [3:0]  iface_en;
    logic [31:0] rt_prefix [N_ROUTES];
    logic [31:0] rt_mask [N_ROUTES];
    logic [31:0] rt_gw [N_ROUTES];
    logic [1:0]  rt_port [N_ROUTES];
    logic        rt_valid [N_ROUTES];
    out_beat_t   owed_decisions [$];
    int          mismatches;

    function new();
      for (int i = 0; i < 4; i++) iface_addr[i] = '0;
      iface_en = '0;
      for (int i = 0; i < N_ROUTES; i++) begin
        rt_prefix[i] = '0;
        rt_mask[i] = '0;
        rt_gw[i] = '0;
        rt_port[i] = '0;
        rt_valid[i] = 1'b0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      if (idx < REG_ENABLE) iface_addr[idx[1:0]] = data;
      else if (idx == REG_ENABLE) iface_en = data[3:0];
    endfunction

    // Ones-complement header checksum with the checksum field taken as zero.
    function logic [15:0] hdr_cksum(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                                    logic [31:0] w3, logic [31:0] w4);
      logic [31:0] acc;
      acc = 32'(w0[31:16]) + w0[15:0] + w1[31:16] + w1[15:0] + w2[31:16]
          + w3[31:16] + w3[15:0] + w4[31:16] + w4[15:0];
      acc = (acc >> 16) + (acc & 32'hFFFF);
      acc = acc + (acc >> 16);
      return ~acc[15:0];
    endfunction

    // Works out the decision for one accepted beat and queues it.
    function void note_item(in_beat_t b);
      out_beat_t r;
      logic local_hit, found;
      logic [7:0] ttl;
      logic [31:0] bmask;
      int best;
      r = '0;
      if (b.kind == KIND_WRITE || b.kind == KIND_CLEAR) begin
        if (b.kind == KIND_WRITE) begin
          rt_prefix[b.route_index] = b.route_dest;
          rt_mask[b.route_index] = b.route_mask;
          rt_gw[b.route_index] = b.route_gateway;
          rt_port[b.route_index] = b.route_port;
          rt_valid[b.route_index] = 1'b1;
        end else begin
          rt_valid[b.route_index] = 1'b0;
        end
        r.action = ACT_UPDATED;
      end else if (b.kind == KIND_HEADER) begin
        ttl = b.hdr_word2[31:24];
        local_hit = 1'b0;
        for (int j = 0; j < N_PORTS; j++)
          if (iface_en[j] && iface_addr[j] == b.dst_addr) local_hit = 1'b1;
        if (b.frame_len < MIN_FRAME) begin
          r.action = ACT_SHORT;
        end else if (hdr_cksum(b.hdr_word0, b.hdr_word1, b.hdr_word2, b.src_addr,
                               b.dst_addr) != b.hdr_word2[15:0]) begin
          r.action = ACT_BAD_CKSUM;
        end else if (local_hit) begin
          if (b.hdr_word2[23:16] == PROTO_ICMP) begin
            r.action = ACT_ECHO;
            r.reply_type = ICMP_ECHO_REPLY;
          end else begin
            r.action = ACT_PORT_UNR;
            r.reply_type = ICMP_DEST_UNR;
            r.reply_code = CODE_PORT;
          end
        end else if (ttl <= 8'd1) begin
          r.action = ACT_TTL_EXC;
          r.reply_type = ICMP_TIME_EXC;
        end else begin
          found = 1'b0;
          bmask = '0;
          best = 0;
          for (int j = 0; j < N_ROUTES; j++) begin
            if (rt_valid[j] && (rt_mask[j] & b.dst_addr) == rt_prefix[j] &&
                (!found || rt_mask[j] > bmask)) begin
              found = 1'b1;
              best = j;
              bmask = rt_mask[j];
            end
          end
          if (!found) begin
            r.action = ACT_NET_UNR;
            r.reply_type = ICMP_DEST_UNR;
            r.reply_code = CODE_NET;
          end else begin
            r.action = ACT_FORWARD;
            r.new_ttl = ttl - 8'd1;
            r.new_checksum = hdr_cksum(b.hdr_word0, b.hdr_word1,
                                       {ttl - 8'd1, b.hdr_word2[23:0]},
                                       b.src_addr, b.dst_addr);
            r.out_port = rt_port[best];
            r.next_hop = rt_gw[best];
          end
        end
      end
      owed_decisions.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h want %0h", what, got, want);
      mismatches++;
    endtask

    // Compares one result beat against the oldest owed decision.
    task check_result(out_beat_t got);
      out_beat_t w;
      if (owed_decisions.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(got.action), '0);
        return;
      end
      w = owed_decisions.pop_front();
      if (got.action !== w.action)
        report_mismatch("action", 32'(got.action), 32'(w.action));
      if (got.out_port !== w.out_port)
        report_mismatch("out_port", 32'(got.out_port), 32'(w.out_port));
      if (got.next_hop !== w.next_hop) report_mismatch("next_hop", got.next_hop, w.next_hop);
      if (got.new_ttl !== w.new_ttl)
        report_mismatch("new_ttl", 32'(got.new_ttl), 32'(w.new_ttl));
      if (got.new_checksum !== w.new_checksum)
        report_mismatch("new_checksum", 32'(got.new_checksum), 32'(w.new_checksum));
      if (got.reply_type !== w.reply_type)
        report_mismatch("reply_type", 32'(got.reply_type), 32'(w.reply_type));
      if (got.reply_code !== w.reply_code)
        report_mismatch("reply_code", 32'(got.reply_code), 32'(w.reply_code));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  in_beat_t   item;
  logic       done;
  out_beat_t  result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  fwd_scoreboard sb;
  int idle_pct;
  logic [31:0] addr_pool [8];

  ipv4_forwarding_decision_core #(.ROUTE_ENTRIES(N_ROUTES), .NUM_PORTS(N_PORTS)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result beats are sampled at the edge that ends their cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // Drives one input beat and waits for the edge that accepts it. The first
  // edge always passes with start low; the block is still busy there anyway.
  task automatic send_item(in_beat_t b);
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    item <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(b);
    start <= 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every owed decision has come back.
  task automatic drain();
    while (sb.owed_decisions.size() != 0) @(posedge clk);
    repeat (N_ROUTES + 8) @(posedge clk);
  endtask

  // Fully random input beat.
  function automatic in_beat_t rand_beat();
    logic [287:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_beat_t)-1:0];
  endfunction

  // Builds a header with a correct checksum unless told otherwise.
  function automatic in_beat_t make_header(logic [7:0] ttl, logic [7:0] proto,
                                           logic [31:0] dst, logic good);
    in_beat_t b;
    b = rand_beat();
    b.kind = KIND_HEADER;
    b.frame_len = 16'($urandom_range(34, 1600));
    b.hdr_word2[31:16] = {ttl, proto};
    b.dst_addr = dst;
    b.hdr_word2[15:0] = sb.hdr_cksum(b.hdr_word0, b.hdr_word1, b.hdr_word2,
                                     b.src_addr, b.dst_addr);
    if (!good) b.hdr_word2[15:0] ^= 16'(1 << $urandom_range(15));
    return b;
  endfunction

  function automatic in_beat_t make_route(logic [1:0] kind, logic [3:0] idx,
                                          logic [31:0] dst, int plen);
    in_beat_t b;
    b = rand_beat();
    b.kind = kind;
    b.route_index = idx;
    b.route_mask = (plen == 0) ? 32'h0 : ~((32'h1 << (32 - plen)) - 1);
    b.route_dest = dst & b.route_mask;
    return b;
  endfunction

  // Destination from a small pool, so that routes and interfaces hit, a pool
  // address with random low bits, or fully random.
  function automatic logic [31:0] pick_dst();
    logic [31:0] a;
    a = addr_pool[$urandom_range(7)];
    case ($urandom_range(3))
      0: return $urandom;
      1: return a;
      default: return a ^ 32'($urandom_range(255));
    endcase
  endfunction

  task automatic random_item();
    in_beat_t b;
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      b = make_route(KIND_WRITE, 4'($urandom), pick_dst(), $urandom_range(32));
      if ($urandom_range(3) == 0) b.route_dest = $urandom;
    end else if (pick < 27) begin
      b = make_route(KIND_CLEAR, 4'($urandom), $urandom, 0);
    end else if (pick < 30) begin
      b = rand_beat();
      b.kind = KIND_UNUSED;
    end else begin
      b = make_header(8'($urandom_range(3) == 0 ? $urandom_range(2) : $urandom),
                      ($urandom_range(3) == 0) ? PROTO_ICMP : 8'($urandom),
                      pick_dst(), $urandom_range(9) != 0);
      if ($urandom_range(9) == 0) b.frame_len = 16'($urandom_range(40));
      else if ($urandom_range(19) == 0) b.frame_len = 16'($urandom);
    end
    send_item(b);
  endtask

  initial begin
    in_beat_t b;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: drops, expiry and unreachable answers with an empty table and no interfaces.
    b = make_header(8'd64, 8'd6, addr_pool[0], 1'b1);
    b.frame_len = 16'd33;
    send_item(b);
    b.frame_len = 16'd0;
    send_item(b);
    b.frame_len = MIN_FRAME;
    send_item(b);
    send_item(make_header(8'd64, 8'd6, addr_pool[0], 1'b0));
    send_item(make_header(8'd0, 8'd6, addr_pool[0], 1'b1));
    send_item(make_header(8'd1, 8'd6, addr_pool[0], 1'b1));
    send_item(make_header(8'd2, 8'd6, addr_pool[0], 1'b1));
    drain();

    // Interfaces: extremes of address, only some enabled.
    write_reg(REG_IFACE0, addr_pool[1]);
    write_reg(REG_IFACE1, 32'h0);
    write_reg(REG_IFACE2, 32'hFFFF_FFFF);
    write_reg(REG_IFACE3, addr_pool[2]);
    write_reg(REG_ENABLE, 32'hB);
    send_item(make_header(8'd64, PROTO_ICMP, addr_pool[1], 1'b1));
    send_item(make_header(8'd0, 8'd17, addr_pool[1], 1'b1));
    send_item(make_header(8'd64, PROTO_ICMP, 32'h0, 1'b1));
    send_item(make_header(8'd64, PROTO_ICMP, 32'hFFFF_FFFF, 1'b1));
    send_item(make_header(8'd64, 8'd255, addr_pool[2], 1'b1));

    // Routes: default route, equal lengths, longest prefix, clear, index extremes.
    send_item(make_route(KIND_WRITE, 4'd15, 32'h0, 0));
    send_item(make_header(8'd255, 8'd6, addr_pool[3], 1'b1));
    send_item(make_route(KIND_WRITE, 4'd9, addr_pool[3], 16));
    send_item(make_route(KIND_WRITE, 4'd3, addr_pool[3], 16));
    send_item(make_header(8'd2, 8'd6, addr_pool[3], 1'b1));
    send_item(make_route(KIND_WRITE, 4'd0, addr_pool[3], 32));
    send_item(make_header(8'd128, 8'd6, addr_pool[3], 1'b1));
    send_item(make_route(KIND_CLEAR, 4'd0, 32'h0, 0));
    send_item(make_header(8'd128, 8'd6, addr_pool[3], 1'b1));
    send_item(make_route(KIND_CLEAR, 4'd15, 32'h0, 0));
    b = make_route(KIND_UNUSED, 4'd5, 32'h0, 0);
    send_item(b);
    drain();

    // Random phases, each under its own interface setting; idling repeats every four phases.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 58;
        2: idle_pct = 0;
        default: idle_pct = 37;
      endcase
      for (int r = 0; r < 4; r++)
        write_reg(3'(r), ($urandom_range(1) != 0) ? addr_pool[$urandom_range(7)] : $urandom);
      write_reg(REG_ENABLE, (phase == 0) ? 32'h0 : (phase == 7) ? 32'hF : 32'($urandom));
      for (int n = 0; n < 106; n++) random_item();
      drain();
    end

    if (sb.mismatches == 0 && sb.owed_decisions.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
